@@ sv/glzw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_CODE_WIDTH = 12;
  localparam int DICT_SLOTS     = 1 << MAX_CODE_WIDTH;
  localparam int CODE_W         = MAX_CODE_WIDTH;
  localparam int NFC_W          = MAX_CODE_WIDTH + 1;
  localparam int BUF_W          = 2 * MAX_CODE_WIDTH;
  localparam int HELD_W         = $clog2(BUF_W + 1);
  localparam int PAL_ENTRIES    = 256;
  localparam int PAL_W          = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int STEP_W         = 6;

  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  localparam logic [1:0] STATUS_PIXEL = 2'd0;
  localparam logic [1:0] STATUS_END   = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic [7:0]  palette_slot;
    logic [23:0] palette_color;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_last;
    logic [1:0] status;
  } pixel_t;

  typedef struct packed {
    logic load;
    logic final_now;
    logic run_last;
    logic close;
    logic close_last;
  } hold_ctl_t;

  typedef struct packed {
    logic busy;
  } hold_stat_t;

endpackage

@@ sv/glzw_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_outq
// Hold stage that settles the last-of-run flag, then the output register.
// ----------------------------------------------------------------------------
module glzw_outq import glzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  hold_ctl_t  ctl,
  input  pixel_t     res,
  output hold_stat_t stat,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output pixel_t     pixel
);

  logic   hold_valid;
  logic   hold_final;
  logic   hold_last;
  pixel_t hold;
  pixel_t hold_out;
  logic   move;

  assign move = hold_valid && hold_final && (!pixel_valid || !pixel_stall);
  assign stat.busy = hold_valid;

  always_comb begin
    hold_out          = hold;
    hold_out.run_last = hold_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid  <= 1'b0;
      hold_final  <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (move) begin
        pixel_valid <= 1'b1;
        pixel       <= hold_out;
        hold_valid  <= 1'b0;
      end else if (pixel_valid && !pixel_stall) begin
        pixel_valid <= 1'b0;
      end
      if (ctl.close && hold_valid && !hold_final) begin
        hold_final <= 1'b1;
        hold_last  <= ctl.close_last;
      end
      if (ctl.load) begin
        hold_valid <= 1'b1;
        hold       <= res;
        hold_final <= ctl.final_now;
        hold_last  <= ctl.run_last;
      end
    end
  end

endmodule

@@ sv/glzw_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_core
// Code unpacking, dictionary walk, reversal stack and palette lookup.
// ----------------------------------------------------------------------------
module glzw_core import glzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output hold_ctl_t  ctl,
  output pixel_t     res,
  input  hold_stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_WALKRD = 4'd3;
  localparam logic [3:0] S_KFIX   = 4'd4;
  localparam logic [3:0] S_ADD    = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_PAL    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_HALT   = 4'd9;

  localparam logic [NFC_W-1:0] SLOTS = NFC_W'(DICT_SLOTS);

  function automatic logic [3:0] eff_min(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < 4'd2) r = 4'd2;
    if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

  logic [3:0]        state;
  logic [3:0]        min_code_size;
  logic [BUF_W-1:0]  bit_buffer;
  logic [HELD_W-1:0] bits_held;
  logic [3:0]        code_width;
  logic [NFC_W-1:0]  next_free_code;
  logic [CODE_W-1:0] previous_code;
  logic              after_clear;
  logic              stopped;
  logic [NFC_W-1:0]  stack_count;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] cur;
  logic              kwk;
  logic [7:0]        first_ch;
  logic [STEP_W-1:0] step_cnt;
  logic [1:0]        halt_status;
  logic [7:0]        pix_idx;

  logic [CODE_W+7:0] dict_mem [DICT_SLOTS];
  logic [7:0]        stack_mem [DICT_SLOTS];
  logic [23:0]       pal_mem [PAL_ENTRIES];
  logic [CODE_W+7:0] dict_q;
  logic [7:0]        stack_q;
  logic [23:0]       pal_q;

  logic              dict_we;
  logic              stack_we;
  logic [CODE_W-1:0] stack_wa;
  logic [7:0]        stack_wd;
  logic [CODE_W-1:0] stack_ra;
  logic              pal_we;

  logic [3:0]        m;
  logic [CODE_W-1:0] clr;
  logic [CODE_W-1:0] mask;
  logic              busy_idle;
  logic              accept;
  logic [3:0]        m_cfg;
  logic [NFC_W-1:0]  nfc_inc;
  logic              stack_room;

  assign m          = eff_min(min_code_size);
  assign clr        = CODE_W'(1) << m;
  assign mask       = CODE_W'((NFC_W'(1) << code_width) - NFC_W'(1));
  assign busy_idle  = !stopped && (bits_held >= HELD_W'(code_width));
  assign item_stall = !(state == S_IDLE && !busy_idle);
  assign accept     = item_valid && !item_stall;
  assign m_cfg      = eff_min(cfg_data);
  assign nfc_inc    = next_free_code + NFC_W'(1);
  assign stack_room = stack_count < SLOTS;
  assign pal_we     = accept && item.command == CMD_PALETTE &&
                      {1'b0, item.palette_slot} < 9'(PAL_ENTRIES);
  assign dict_we    = state == S_ADD && next_free_code < SLOTS;
  assign stack_ra   = CODE_W'(stack_count - NFC_W'(1));

  always_comb begin
    stack_we = 1'b0;
    stack_wa = stack_count[CODE_W-1:0];
    stack_wd = 8'd0;
    case (state)
      S_DECODE: begin
        stack_we = code != clr && code != clr + CODE_W'(1) && after_clear && code < clr;
        stack_wd = code[7:0];
      end
      S_WALK: begin
        stack_we = cur < clr && stack_room;
        stack_wd = cur[7:0];
      end
      S_WALKRD: begin
        stack_we = stack_room;
        stack_wd = dict_q[7:0];
      end
      S_KFIX: begin
        stack_we = 1'b1;
        stack_wa = '0;
        stack_wd = first_ch;
      end
      default: begin
        stack_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    res = '0;
    case (state)
      S_IDLE: begin
        ctl.close      = !busy_idle;
        ctl.close_last = 1'b1;
      end
      S_POP: begin
        ctl.close = stack_count != '0;
      end
      S_HALT: begin
        ctl.close     = 1'b1;
        ctl.load      = !stat.busy;
        ctl.final_now = 1'b1;
        ctl.run_last  = 1'b1;
        res.status    = halt_status;
      end
      S_EMIT: begin
        ctl.load        = 1'b1;
        res.pixel_index = pix_idx;
        if ({1'b0, pix_idx} < 9'(PAL_ENTRIES)) begin
          res.red   = pal_q[23:16];
          res.green = pal_q[15:8];
          res.blue  = pal_q[7:0];
        end
        res.status = STATUS_PIXEL;
        if (stack_count != '0) begin
          ctl.final_now = 1'b1;
        end else if (bits_held < HELD_W'(code_width)) begin
          ctl.final_now = 1'b1;
          ctl.run_last  = 1'b1;
        end else if (step_cnt == '1) begin
          ctl.final_now = 1'b1;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[next_free_code[CODE_W-1:0]] <= {previous_code, first_ch};
    end
    dict_q <= dict_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    stack_q <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[item.palette_slot[PAL_W-1:0]] <= item.palette_color;
    end
    pal_q <= pal_mem[stack_q[PAL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      min_code_size  <= rst ? MIN_SIZE_RESET : cfg_data;
      state          <= S_IDLE;
      bit_buffer     <= '0;
      bits_held      <= '0;
      code_width     <= (rst ? eff_min(MIN_SIZE_RESET) : m_cfg) + 4'd1;
      next_free_code <= (NFC_W'(1) << (rst ? eff_min(MIN_SIZE_RESET) : m_cfg)) + NFC_W'(2);
      previous_code  <= '0;
      after_clear    <= 1'b1;
      stopped        <= 1'b0;
      stack_count    <= '0;
      step_cnt       <= '0;
    end else begin
      if (stack_we && state != S_KFIX && stack_room) begin
        stack_count <= stack_count + NFC_W'(1);
      end
      if (ctl.load) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (busy_idle) begin
            code       <= bit_buffer[CODE_W-1:0] & mask;
            bit_buffer <= bit_buffer >> code_width;
            bits_held  <= bits_held - HELD_W'(code_width);
            state      <= S_DECODE;
          end else if (accept) begin
            step_cnt <= '0;
            if (item.command == CMD_DATA && !stopped) begin
              bit_buffer <= bit_buffer | (BUF_W'(item.data_byte) << bits_held);
              bits_held  <= bits_held + HELD_W'(8);
            end
          end
        end
        S_DECODE: begin
          if (code == clr) begin
            next_free_code <= NFC_W'(clr) + NFC_W'(2);
            code_width     <= m + 4'd1;
            after_clear    <= 1'b1;
            state          <= S_IDLE;
          end else if (code == clr + CODE_W'(1)) begin
            halt_status <= STATUS_END;
            state       <= S_HALT;
          end else if (after_clear) begin
            if (code < clr) begin
              after_clear   <= 1'b0;
              previous_code <= code;
              state         <= S_POP;
            end else begin
              halt_status <= STATUS_BAD;
              state       <= S_HALT;
            end
          end else if (NFC_W'(code) < next_free_code) begin
            cur   <= code;
            kwk   <= 1'b0;
            state <= S_WALK;
          end else if (NFC_W'(code) == next_free_code) begin
            cur         <= previous_code;
            kwk         <= 1'b1;
            stack_count <= NFC_W'(1);
            state       <= S_WALK;
          end else begin
            halt_status <= STATUS_BAD;
            state       <= S_HALT;
          end
        end
        S_WALK: begin
          if (cur >= clr && stack_room) begin
            state <= S_WALKRD;
          end else begin
            first_ch <= cur[7:0];
            state    <= kwk ? S_KFIX : S_ADD;
          end
        end
        S_WALKRD: begin
          cur   <= dict_q[CODE_W+7:8];
          state <= S_WALK;
        end
        S_KFIX: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (next_free_code < SLOTS) begin
            next_free_code <= nfc_inc;
            if (nfc_inc == (NFC_W'(1) << code_width) &&
                code_width < 4'(MAX_CODE_WIDTH)) begin
              code_width <= code_width + 4'd1;
            end
          end
          previous_code <= code;
          state         <= S_POP;
        end
        S_POP: begin
          if (stack_count == '0) begin
            state <= S_IDLE;
          end else if (!stat.busy) begin
            stack_count <= stack_count - NFC_W'(1);
            state       <= S_PAL;
          end
        end
        S_PAL: begin
          pix_idx <= stack_q;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          state <= S_POP;
        end
        S_HALT: begin
          if (!stat.busy) begin
            stopped    <= 1'b1;
            bit_buffer <= '0;
            bits_held  <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/gif_lzw_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF LZW image data decoder with palette lookup, one pixel per output beat.
// ----------------------------------------------------------------------------
// A byte beat is taken when the decoder is idle. Each code is extracted and
// then classified; a dictionary code then walks its links through the walk
// and read states before the add state, with a fix-up state first for a code
// not yet in the table. Each pixel passes through stack read, palette read,
// emit and the hold hand-off.
// Reset is synchronous; the memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module gif_lzw_decoder import glzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output pixel_t     pixel
);

  hold_ctl_t  ctl;
  hold_stat_t stat;
  pixel_t     res;

  glzw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .ctl        (ctl),
    .res        (res),
    .stat       (stat)
  );

  glzw_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .res         (res),
    .stat        (stat),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GIF LZW decoder. A short directed table runs
// first, then LZW code streams built on the fly for random minimum code
// sizes, noise items and broken streams. Every pixel beat is checked against
// a predictor of the decoder.
// ----------------------------------------------------------------------------
module tb_top;
  import glzw_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 300;
  localparam int TOTAL_ITEMS = 470;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [3:0] cfg_data;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       pixel_valid;
  logic       pixel_stall;
  pixel_t     pixel;

  gif_lzw_decoder u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  int errors = 0;
  int cycles = 0;
  int items_sent;
  bit no_idle;
  int hold_req;

  // Decoder predictor state.
  logic [11:0] d_prefix [DICT_SLOTS];
  logic [7:0]  d_suffix [DICT_SLOTS];
  logic [23:0] d_pal [256];
  logic [7:0]  d_stack [DICT_SLOTS];
  int unsigned d_sp, d_buf, d_held, d_width, d_nfc, d_prev, d_msize;
  bit          d_after, d_stop;
  pixel_t      step_q[$];
  pixel_t      pixels_due[$];

  function automatic int unsigned eff_m(int unsigned v);
    int unsigned m;
    m = v & 15;
    if (m < 2) m = 2;
    if (m > 8) m = 8;
    return m;
  endfunction

  function void d_restart();
    int unsigned m;
    m = eff_m(d_msize);
    d_buf = 0; d_held = 0; d_width = m + 1; d_nfc = (1 << m) + 2;
    d_prev = 0; d_after = 1; d_stop = 0; d_sp = 0;
  endfunction

  function bit d_busy();
    return !d_stop && (d_sp > 0 || d_held >= d_width);
  endfunction

  function void d_push(int unsigned v);
    if (d_sp < DICT_SLOTS) begin
      d_stack[d_sp] = v[7:0];
      d_sp++;
    end
  endfunction

  function int unsigned d_first(int unsigned code, int unsigned clr);
    int unsigned c;
    c = code & 12'hFFF;
    for (int i = 0; i < DICT_SLOTS && c >= clr; i++) c = d_prefix[c];
    return c & 8'hFF;
  endfunction

  function void d_push_str(int unsigned code, int unsigned clr);
    int unsigned c;
    c = code & 12'hFFF;
    for (int i = 0; i < DICT_SLOTS && c >= clr && d_sp < DICT_SLOTS; i++) begin
      d_push(d_suffix[c]);
      c = d_prefix[c];
    end
    d_push(c);
  endfunction

  function void d_emit(int unsigned idx, logic [1:0] st);
    pixel_t p;
    logic [23:0] rgb;
    rgb = (st == STATUS_PIXEL) ? d_pal[idx & 8'hFF] : 24'd0;
    p.pixel_index = idx[7:0];
    p.red = rgb[23:16];
    p.green = rgb[15:8];
    p.blue = rgb[7:0];
    p.run_last = 1'b0;
    p.status = st;
    step_q.push_back(p);
  endfunction

  function void d_halt(logic [1:0] st);
    d_emit(0, st);
    d_stop = 1; d_buf = 0; d_held = 0;
  endfunction

  function void d_decode(int unsigned code);
    int unsigned m, clr, ch;
    m = eff_m(d_msize);
    clr = 1 << m;
    if (code == clr) begin
      d_nfc = clr + 2; d_width = m + 1; d_after = 1;
      return;
    end
    if (code == clr + 1) begin
      d_halt(STATUS_END);
      return;
    end
    if (d_after) begin
      if (code < clr) begin
        d_push(code); d_after = 0; d_prev = code;
      end else begin
        d_halt(STATUS_BAD);
      end
      return;
    end
    if (code < d_nfc) begin
      d_push_str(code, clr);
      ch = (d_sp > 0) ? d_stack[d_sp - 1] : 0;
    end else if (code == d_nfc) begin
      ch = d_first(d_prev, clr);
      d_push(ch);
      d_push_str(d_prev, clr);
    end else begin
      d_halt(STATUS_BAD);
      return;
    end
    if (d_nfc < DICT_SLOTS) begin
      d_prefix[d_nfc] = d_prev[11:0];
      d_suffix[d_nfc] = ch[7:0];
      d_nfc++;
      if (d_nfc == (1 << d_width) && d_width < MAX_CODE_WIDTH) d_width++;
    end
    d_prev = code & 12'hFFF;
  endfunction

  function void d_step(item_t it, bit take);
    int unsigned code;
    step_q.delete();
    if (take && !d_busy()) begin
      if (it.command == CMD_PALETTE) begin
        d_pal[it.palette_slot] = it.palette_color;
      end else if (!d_stop) begin
        d_buf = d_buf | (int'(it.data_byte) << d_held);
        d_held += 8;
      end
    end
    forever begin
      while (d_sp > 0 && step_q.size() < 64) begin
        d_sp--;
        d_emit(d_stack[d_sp], STATUS_PIXEL);
      end
      if (d_sp > 0 || d_stop || d_held < d_width || step_q.size() >= 64) break;
      code = d_buf & ((1 << d_width) - 1);
      d_buf = (d_buf >> d_width) & 24'hFFFFFF;
      d_held -= d_width;
      d_decode(code);
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = !d_busy();
    foreach (step_q[i]) pixels_due.push_back(step_q[i]);
  endfunction

  function void predict_item(item_t it);
    d_step(it, 1'b1);
    while (d_busy()) d_step(it, 1'b0);
  endfunction

  function automatic item_t mk_item(logic cmd, logic [7:0] b, logic [7:0] slot,
                                    logic [23:0] color);
    item_t it;
    it.command = cmd;
    it.data_byte = b;
    it.palette_slot = slot;
    it.palette_color = color;
    return it;
  endfunction

  function automatic item_t mk_data(logic [7:0] b);
    return mk_item(CMD_DATA, b, 8'($urandom), 24'($urandom));
  endfunction

  function automatic item_t mk_pal(logic [7:0] slot, logic [23:0] color);
    return mk_item(CMD_PALETTE, 8'($urandom), slot, color);
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 10) ? $urandom_range(1, 6) : 0;
    predict_item(it);
    items_sent++;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_min_size(logic [3:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    d_msize = v;
    d_restart();
  endtask

  // Code stream builder, mirroring the decoder's width growth.
  int unsigned g_m, g_clr, g_nfc, g_w, g_acc, g_nbits;
  bit g_after;

  task automatic gen_start(logic [3:0] v);
    write_min_size(v);
    g_m = eff_m(v); g_clr = 1 << g_m; g_nfc = g_clr + 2; g_w = g_m + 1;
    g_after = 1; g_acc = 0; g_nbits = 0;
  endtask

  task automatic put_code(int unsigned c);
    g_acc = g_acc | (c << g_nbits);
    g_nbits += g_w;
    while (g_nbits >= 8) begin
      send_item(mk_data(g_acc[7:0]));
      g_acc = g_acc >> 8;
      g_nbits -= 8;
    end
    if (c == g_clr) begin
      g_nfc = g_clr + 2; g_w = g_m + 1; g_after = 1;
    end else if (c == g_clr + 1) begin
    end else if (g_after) begin
      g_after = 0;
    end else if (g_nfc < DICT_SLOTS) begin
      g_nfc++;
      if (g_nfc == (1 << g_w) && g_w < MAX_CODE_WIDTH) g_w++;
    end
  endtask

  task automatic gen_flush();
    if (g_nbits > 0) send_item(mk_data(g_acc[7:0]));
    g_acc = 0; g_nbits = 0;
  endtask

  task automatic put_good_code(int lit_pct);
    int unsigned r, c;
    r = $urandom_range(0, 99);
    if (g_after) begin
      c = (r < 8) ? g_clr : $urandom_range(0, g_clr - 1);
    end else if (r < lit_pct) begin
      c = $urandom_range(0, g_clr - 1);
    end else if (r < 80) begin
      c = $urandom_range(0, g_nfc - 1);
      if (c == g_clr || c == g_clr + 1) c = $urandom_range(0, g_clr - 1);
    end else if (r < 95 && g_nfc < DICT_SLOTS) begin
      c = g_nfc;
    end else begin
      c = g_clr;
    end
    put_code(c);
  endtask

  task automatic put_bad_code();
    if (g_after) put_code($urandom_range(g_clr + 2, (1 << g_w) - 1));
    else if (g_nfc + 1 < (1 << g_w)) put_code($urandom_range(g_nfc + 1, (1 << g_w) - 1));
    else put_code(g_clr + 1);
  endtask

  // Receiver stall, with a long hold whenever one is requested.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      pixel_stall <= 1'b1;
    end else begin
      pixel_stall <= (!no_idle && $urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel beat %h", $time, pixel);
        errors++;
      end else begin
        pixel_t w;
        w = pixels_due.pop_front();
        if (w.pixel_index !== pixel.pixel_index || w.red !== pixel.red ||
            w.green !== pixel.green || w.blue !== pixel.blue ||
            w.run_last !== pixel.run_last || w.status !== pixel.status) begin
          $display("%0t: pixel mismatch, expected idx %h rgb %h%h%h last %b st %0d, got idx %h rgb %h%h%h last %b st %0d",
                   $time, w.pixel_index, w.red, w.green, w.blue, w.run_last, w.status,
                   pixel.pixel_index, pixel.red, pixel.green, pixel.blue,
                   pixel.run_last, pixel.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** gif_lzw_decoder: FAILED **");
      $finish;
    end
  end

  typedef struct {
    item_t  it;
    bit     chk;
    pixel_t want;
  } dir_row_t;

  dir_row_t dir_rows[5];

  initial begin
    int unsigned len, kind;
    int dir_errors;
    dir_errors = 0; items_sent = 0; no_idle = 0;
    hold_req = 0;
    rst = 1'b1; cfg_write = 1'b0; cfg_data = '0;
    item_valid = 1'b0; item = '0;
    d_msize = MIN_SIZE_RESET;
    d_restart();

    // Reset size 8: literal 0 in 9 bits, then the end code.
    dir_rows[0] = '{mk_pal(8'd0, 24'hA5C3E1), 1'b0, '0};
    dir_rows[1] = '{mk_data(8'h00), 1'b0, '0};
    dir_rows[2] = '{mk_data(8'h02), 1'b1,
                    pixel_t'{8'd0, 8'hA5, 8'hC3, 8'hE1, 1'b1, STATUS_PIXEL}};
    dir_rows[3] = '{mk_data(8'h02), 1'b1,
                    pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, STATUS_END}};
    dir_rows[4] = '{mk_data(8'hFF), 1'b0, '0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].chk) begin
        if (step_q.size() != 1) begin
          $display("%0t: directed row %0d, expected %h, predicted %0d results",
                   $time, i, dir_rows[i].want, step_q.size());
          dir_errors++;
        end else if (step_q[0] !== dir_rows[i].want) begin
          $display("%0t: directed row %0d, expected %h, predicted %h",
                   $time, i, dir_rows[i].want, step_q[0]);
          dir_errors++;
        end
      end
    end
    drain();

    send_item(mk_pal(8'd0, 24'h000000));
    send_item(mk_pal(8'd255, 24'hFFFFFF));
    for (int s = 1; s < 255; s++) send_item(mk_pal(s[7:0], 24'($urandom)));
    drain();

    // Smallest size: a repeated-string code twice, a clear, a literal, then the end code.
    gen_start(4'd2);
    put_code(1); put_code(6); put_code(0); put_code(7);
    put_code(4); put_code(3); put_code(5);
    gen_flush();
    drain();
    // Size 0 saturates to 2; a non-literal right after clear is rejected.
    gen_start(4'd0);
    put_code(2); put_code(4); put_code(6);
    gen_flush();
    send_item(mk_data(8'hA5));
    drain();
    // Size 15 saturates to 8.
    gen_start(4'd15);
    put_code(255); put_code(0); put_code(258); put_code(256); put_code(128);
    put_code(257);
    gen_flush();
    drain();

    for (int seq = 0; items_sent < TOTAL_ITEMS; seq++) begin
      no_idle = (seq % 5 == 3);
      case ($urandom_range(0, 3))
        0: gen_start(4'd2);
        1: gen_start(4'd8);
        default: gen_start(4'($urandom));
      endcase
      if (seq == 2) hold_req++;
      len = $urandom_range(4, 40);
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat (len / 3 + 1) send_item(mk_data(8'($urandom)));
      end else begin
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 6) send_item(mk_pal(8'($urandom), 24'($urandom)));
          put_good_code(35);
        end
        if (kind < 22) put_bad_code();
        else if (kind < 92) put_code(g_clr + 1);
        gen_flush();
      end
      if ($urandom_range(0, 3) == 0) send_item(mk_data(8'($urandom)));
      drain();
    end
    no_idle = 0;
    drain();

    if (errors == 0 && dir_errors == 0) begin
      $display("** gif_lzw_decoder: PASSED **");
    end else begin
      $display("** gif_lzw_decoder: FAILED **");
    end
    $finish;
  end

endmodule
